// ----- sv/nsdw_pkg.sv -----
package nsdw_pkg;

	localparam int NUM_W       = 16;
	localparam int ADDR_W      = 5;
	localparam int SEG_W       = 7;
	localparam int MEM_BYTES   = 20;
	localparam int DIGIT_COUNT = 5;
	// first byte that holds a digit (digit k lands at byte k+1)
	localparam int DIGIT_BASE  = 2;

	localparam int ADDR_CNT_W  = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
	localparam int DIG_IDX_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	// x / 10 == (x * 0xCCCD) >> 19 for every x below 81920
	localparam logic [NUM_W-1:0] DIV10_MUL   = 16'hCCCD;
	localparam int               DIV10_SHIFT = 19;

	typedef logic [DIGIT_COUNT-1:0][SEG_W-1:0] digit_set_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		FRONT_IDLE,
		FRONT_SPLIT,
		FRONT_PUSH
	} front_state_t;

	typedef enum logic {
		BACK_IDLE,
		BACK_EMIT
	} back_state_t;

	function automatic logic [SEG_W-1:0] seg_of_digit(input logic [3:0] d);
		logic [SEG_W-1:0] p;
		case (d)
			4'd0: p = 7'h5F;
			4'd1: p = 7'h06;
			4'd2: p = 7'h6B;
			4'd3: p = 7'h2F;
			4'd4: p = 7'h36;
			4'd5: p = 7'h3D;
			4'd6: p = 7'h7D;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7F;
			4'd9: p = 7'h3F;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// ----- sv/nsdw_front.sv -----
module nsdw_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [nsdw_pkg::NUM_W-1:0] number,
	output logic                busy,
	input  nsdw_pkg::queue_status_t q_status,
	output logic                push,
	output nsdw_pkg::digit_set_t push_data
);

	nsdw_pkg::front_state_t state_q, state_d;
	logic [nsdw_pkg::NUM_W-1:0]     value_q;
	logic [nsdw_pkg::DIG_IDX_W-1:0] cnt_q;
	nsdw_pkg::digit_set_t           pats_q;

	logic [2*nsdw_pkg::NUM_W-1:0] prod;
	logic [nsdw_pkg::NUM_W-1:0]   quot;
	logic [nsdw_pkg::NUM_W-1:0]   rem_full;
	logic [3:0]                   digit;
	logic                         load, step, last_step;

	// one decimal digit per cycle: reciprocal multiply, then remainder
	assign prod     = value_q * nsdw_pkg::DIV10_MUL;
	assign quot     = nsdw_pkg::NUM_W'(prod >> nsdw_pkg::DIV10_SHIFT);
	assign rem_full = value_q - ((quot << 3) + (quot << 1));
	assign digit    = rem_full[3:0];
	assign last_step = (cnt_q == nsdw_pkg::DIG_IDX_W'(nsdw_pkg::DIGIT_COUNT - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			nsdw_pkg::FRONT_IDLE:  if (start) state_d = nsdw_pkg::FRONT_SPLIT;
			nsdw_pkg::FRONT_SPLIT: if (last_step) state_d = nsdw_pkg::FRONT_PUSH;
			nsdw_pkg::FRONT_PUSH:  if (!q_status.full) state_d = nsdw_pkg::FRONT_IDLE;
			default:               state_d = nsdw_pkg::FRONT_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		load = 1'b0;
		step = 1'b0;
		push = 1'b0;
		case (state_q)
			nsdw_pkg::FRONT_IDLE: begin
				busy = 1'b0;
				load = start;
			end
			nsdw_pkg::FRONT_SPLIT: step = 1'b1;
			nsdw_pkg::FRONT_PUSH:  push = !q_status.full;
			default:               busy = 1'b1;
		endcase
	end

	assign push_data = pats_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsdw_pkg::FRONT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= number;
			cnt_q   <= '0;
		end else if (step) begin
			value_q <= quot;
			cnt_q   <= cnt_q + 1'b1;
			// leading zeros blank, but the units digit always shows
			if (value_q != '0 || cnt_q == '0) begin
				pats_q[cnt_q] <= nsdw_pkg::seg_of_digit(digit);
			end else begin
				pats_q[cnt_q] <= '0;
			end
		end
	end

endmodule

// ----- sv/nsdw_queue.sv -----
module nsdw_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nsdw_pkg::digit_set_t push_data,
	input  logic                 pop,
	output nsdw_pkg::digit_set_t pop_data,
	output nsdw_pkg::queue_status_t status
);

	nsdw_pkg::digit_set_t slots_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign pop_data     = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= push_data;
	end

endmodule

// ----- sv/nsdw_back.sv -----
module nsdw_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nsdw_pkg::queue_status_t       q_status,
	input  nsdw_pkg::digit_set_t          pop_data,
	output logic                          pop,
	output logic                          write_strobe,
	output logic [nsdw_pkg::ADDR_W-1:0]   byte_address,
	output logic [nsdw_pkg::SEG_W-1:0]    segment_pattern,
	output logic                          last
);

	nsdw_pkg::back_state_t state_q, state_d;
	logic [nsdw_pkg::ADDR_CNT_W-1:0] addr_q;
	nsdw_pkg::digit_set_t            pats_q;

	logic [nsdw_pkg::ADDR_CNT_W-1:0] off;
	logic                            in_digits, at_end;

	assign at_end    = (addr_q == nsdw_pkg::ADDR_CNT_W'(nsdw_pkg::MEM_BYTES - 1));
	assign off       = addr_q - nsdw_pkg::ADDR_CNT_W'(nsdw_pkg::DIGIT_BASE);
	assign in_digits = (addr_q >= nsdw_pkg::ADDR_CNT_W'(nsdw_pkg::DIGIT_BASE)) &&
		({1'b0, off} < (nsdw_pkg::ADDR_CNT_W + 1)'(nsdw_pkg::DIGIT_COUNT));

	always_comb begin
		state_d = state_q;
		case (state_q)
			nsdw_pkg::BACK_IDLE: if (!q_status.empty) state_d = nsdw_pkg::BACK_EMIT;
			nsdw_pkg::BACK_EMIT: if (at_end) state_d = nsdw_pkg::BACK_IDLE;
			default:             state_d = nsdw_pkg::BACK_IDLE;
		endcase
	end

	always_comb begin
		pop          = 1'b0;
		write_strobe = 1'b0;
		case (state_q)
			nsdw_pkg::BACK_IDLE: pop = !q_status.empty;
			nsdw_pkg::BACK_EMIT: write_strobe = 1'b1;
			default:             write_strobe = 1'b0;
		endcase
	end

	assign byte_address    = nsdw_pkg::ADDR_W'(addr_q);
	assign segment_pattern = in_digits ? pats_q[off[nsdw_pkg::DIG_IDX_W-1:0]] : '0;
	assign last            = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsdw_pkg::BACK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pats_q <= pop_data;
			addr_q <= '0;
		end else if (write_strobe) begin
			addr_q <= addr_q + 1'b1;
		end
	end

endmodule

// ----- sv/number_to_segment_display_writer_top.sv -----
// Shows a 16-bit unsigned number in decimal on a 20-byte seven-segment
// memory image. A transfer in happens on a rising edge with start high and
// busy low. Each number yields all 20 bytes, addresses 0..19 in order, one
// per cycle while write_strobe is high; last marks byte 19. The receiver
// cannot stall: every strobed byte is taken in that cycle. Digit k (units
// first) sits at byte k+1 for k = 1..5; leading zeros and all other bytes
// are 0, and zero shows as a single 0 at byte 2. Timing: the front splits
// the number one digit per cycle through a reciprocal multiply by 1/10;
// busy stays high while digits are split and pushed, and through any wait
// for a queue slot. The back streams 20 bytes after a one-cycle queue pop,
// so the byte writer sets the sustained rate of numbers. A two-entry queue
// sits between the digit splitter and the byte writer.
module number_to_segment_display_writer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [nsdw_pkg::NUM_W-1:0]         number,
	output logic                               busy,
	output logic                               write_strobe,
	output logic [nsdw_pkg::ADDR_W-1:0]        byte_address,
	output logic [nsdw_pkg::SEG_W-1:0]         segment_pattern,
	output logic                               last
);

	// front to queue
	logic                    push;
	nsdw_pkg::digit_set_t    push_data;
	// queue to back
	logic                    pop;
	nsdw_pkg::digit_set_t    pop_data;
	nsdw_pkg::queue_status_t q_status;

	// digit splitter: accepts numbers, builds the per-digit patterns
	nsdw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.number    (number),
		.busy      (busy),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	// decouples splitter from byte writer
	nsdw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// byte writer: walks the whole image, one byte per cycle
	nsdw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_status        (q_status),
		.pop_data        (pop_data),
		.pop             (pop),
		.write_strobe    (write_strobe),
		.byte_address    (byte_address),
		.segment_pattern (segment_pattern),
		.last            (last)
	);

endmodule

// ----- dv/segment_image_checker.sv -----
`timescale 1ns / 1ps

module segment_image_checker
	import nsdw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [NUM_W-1:0]  number,
	input  logic              write_strobe,
	input  logic [ADDR_W-1:0] byte_address,
	input  logic [SEG_W-1:0]  segment_pattern,
	input  logic              last,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SEG_W-1:0]  pattern;
		logic              last;
	} seg_write_t;

	// patterns for digits 9 down to 0, so index d gives digit d
	localparam logic [9:0][SEG_W-1:0] DIGIT_SEG = {
		7'h3F, 7'h7F, 7'h07, 7'h7D, 7'h3D, 7'h36, 7'h2F, 7'h6B, 7'h06, 7'h5F
	};

	seg_write_t expected_writes[$];

	// build the full memory image for one number and queue its byte writes
	function automatic void predict_image(input logic [NUM_W-1:0] n);
		logic [SEG_W-1:0] image [MEM_BYTES];
		int               value;
		int               a;
		seg_write_t       w;
		for (a = 0; a < MEM_BYTES; a++)
			image[a] = '0;
		value = n;
		if (value == 0) begin
			image[DIGIT_BASE] = DIGIT_SEG[0];
		end else begin
			for (int pos = 1; pos <= DIGIT_COUNT && value != 0; pos++) begin
				if (DIGIT_BASE - 1 + pos < MEM_BYTES)
					image[DIGIT_BASE - 1 + pos] = DIGIT_SEG[value % 10];
				value = value / 10;
			end
		end
		for (a = 0; a < MEM_BYTES; a++) begin
			w.addr    = a[ADDR_W-1:0];
			w.pattern = image[a];
			w.last    = (a == MEM_BYTES - 1);
			expected_writes.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		seg_write_t exp_w;
		if (!arst_n) begin
			expected_writes.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (write_strobe) begin
				if (expected_writes.size() == 0) begin
					$error("unexpected byte write: addr %0d pattern %02h last %0b",
						byte_address, segment_pattern, last);
					fail_count++;
				end else begin
					exp_w = expected_writes.pop_front();
					if (byte_address !== exp_w.addr) begin
						$error("byte_address expected %0d actual %0d", exp_w.addr, byte_address);
						fail_count++;
					end
					if (segment_pattern !== exp_w.pattern) begin
						$error("segment_pattern expected %02h actual %02h",
							exp_w.pattern, segment_pattern);
						fail_count++;
					end
					if (last !== exp_w.last) begin
						$error("last expected %0b actual %0b", exp_w.last, last);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				predict_image(number);
			pending = expected_writes.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import nsdw_pkg::*;

	// cycles without any transfer before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	// settle time after the last byte write
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 480;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic [NUM_W-1:0]  number;
	logic              busy;
	logic              write_strobe;
	logic [ADDR_W-1:0] byte_address;
	logic [SEG_W-1:0]  segment_pattern;
	logic              last;

	int fail_count;
	int pending;
	int idle_cycles;

	// directed values: zero, digit-count boundaries, max, alternating bits,
	// inner zero digits, every digit value in some position
	logic [NUM_W-1:0] directed[$] = '{
		16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
		16'd9999, 16'd10000, 16'd10001, 16'd65535, 16'd65534, 16'd12345,
		16'd2354, 16'd54321, 16'd60000, 16'd40302, 16'h8000,
		16'h5555, 16'hAAAA, 16'd7, 16'd20000, 16'd65530
	};

	number_to_segment_display_writer_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.number          (number),
		.busy            (busy),
		.write_strobe    (write_strobe),
		.byte_address    (byte_address),
		.segment_pattern (segment_pattern),
		.last            (last)
	);

	// predictor and scoreboard live in the checker; the top only drives
	segment_image_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.number          (number),
		.write_strobe    (write_strobe),
		.byte_address    (byte_address),
		.segment_pattern (segment_pattern),
		.last            (last),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog: any input transfer or byte write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || write_strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// Called at a falling edge. Idles for gap cycles, then presents the
	// number and holds start until the transfer happens. Returns at the
	// falling edge after the transfer, with start still high, so a
	// back-to-back item needs no second assignment in that step.
	task automatic send_number(input logic [NUM_W-1:0] n, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start  <= 1'b1;
		number <= n;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Sender holds off until every byte already owed has been written.
	task automatic drain_display_writes();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// Random number: half uniform, a tenth round, the rest with a chosen
	// decimal length, so short numbers with blank leading digits are common.
	function automatic logic [NUM_W-1:0] pick_number();
		int sel;
		int digits;
		int lo;
		int hi;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return NUM_W'($urandom);
		if (sel == 9)
			return ($urandom_range(0, 1) != 0) ? NUM_W'($urandom_range(0, 6) * 10000)
				: NUM_W'($urandom_range(0, 9) * 1000);
		digits = $urandom_range(1, 5);
		lo = (digits == 1) ? 0 : 10 ** (digits - 1);
		hi = (digits == 5) ? 65535 : 10 ** digits - 1;
		return NUM_W'($urandom_range(lo, hi));
	endfunction

	initial begin
		int gap;
		arst_n = 1'b0;
		start  = 1'b0;
		number = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, mostly back to back
		foreach (directed[i])
			send_number(directed[i], (i % 4 == 3) ? $urandom_range(1, 4) : 0);

		// let the image stream run dry once before random traffic
		drain_display_writes();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// every third block of 40 items runs with no sender gaps
			if ((i / 40) % 3 == 0)
				gap = 0;
			else
				gap = $urandom_range(0, 4);
			send_number(pick_number(), gap);
			if (i % 100 == 99)
				drain_display_writes();
		end

		drain_display_writes();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- number_to_segment_display_writer_top.f -----
sv/nsdw_pkg.sv
sv/nsdw_front.sv
sv/nsdw_queue.sv
sv/nsdw_back.sv
sv/number_to_segment_display_writer_top.sv
dv/segment_image_checker.sv
dv/tb.sv
